[sv/bcdep_pkg.sv]
// Shared types, constants and the BCD byte decoder for the RTC date to epoch converter.
package bcdep_pkg;

   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [7:0]  YEAR_WINDOW   = 8'd45;
   localparam logic [11:0] YEAR_SHIFT    = 12'd30;
   localparam logic [11:0] YEAR_BASE     = 12'd1940;
   localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
   localparam logic [11:0] CENTURY       = 12'd100;
   localparam logic [31:0] EPOCH_DAYS    = 32'd719499;
   localparam logic [8:0]  MONTH_FACTOR  = 9'd367;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

   // Reciprocal multipliers: floor(x * R >> S) equals x / D over the ranges in use.
   localparam logic [12:0] RECIP_100     = 13'd5243;
   localparam logic [10:0] RECIP_400     = 11'd1311;
   localparam int unsigned YEAR_RECIP_SH = 19;
   localparam logic [13:0] RECIP_12      = 14'd10923;
   localparam int unsigned MON_RECIP_SH  = 17;

   typedef struct packed {
      logic [7:0]  sec;
      logic [7:0]  min;
      logic [5:0]  hour;
      logic [5:0]  day;
      logic [11:0] year;
      logic [4:0]  mon;
   } bcdep_dec_type;

   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      logic [7:0] hi;
      hi = {4'd0, b[7:4]};
      return {4'd0, b[3:0]} + (hi << 3) + (hi << 1);
   endfunction

endpackage

[sv/bcdep_decode.sv]
// First pipeline stage: BCD decoding, year windowing and March-first month rotation.
module bcdep_decode
   import bcdep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [REQ_DATA_W-1:0] in_data,
   output logic                  out_valid,
   output bcdep_dec_type         out_dec
);

   logic          valid_ff;
   bcdep_dec_type dec_ff;
   bcdep_dec_type dec_in;

   logic [7:0]  year_raw;
   logic [11:0] year_win;
   logic [11:0] year_full;
   logic [4:0]  mon_raw;
   logic [7:0]  hour_val;
   logic [7:0]  day_val;
   logic [7:0]  mon_val;

   always_comb begin
      dec_in.sec = bcd_value(in_data[7:0]);
      dec_in.min = bcd_value(in_data[15:8]);
      hour_val   = bcd_value({2'b00, in_data[21:16]});
      day_val    = bcd_value({2'b00, in_data[29:24]});
      mon_val    = bcd_value({3'b000, in_data[36:32]});
      dec_in.hour = hour_val[5:0];
      dec_in.day  = day_val[5:0];
      mon_raw     = mon_val[4:0];

      year_raw = bcd_value(in_data[47:40]);
      if (year_raw < YEAR_WINDOW) begin
         year_win = {4'd0, year_raw} + YEAR_SHIFT + YEAR_BASE;
      end else begin
         year_win = {4'd0, year_raw} + YEAR_BASE;
      end
      if (year_win < EPOCH_YEAR) begin
         year_full = year_win + CENTURY;
      end else begin
         year_full = year_win;
      end

      if (mon_raw <= 5'd2) begin
         dec_in.mon  = mon_raw + 5'd10;
         dec_in.year = year_full - 12'd1;
      end else begin
         dec_in.mon  = mon_raw - 5'd2;
         dec_in.year = year_full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule

[sv/bcd_rtc_date_to_epoch_seconds.sv]
// Top level: six-stage pipeline from raw RTC BCD bytes to 32-bit Unix seconds.
//
//   channel   direction   handshake               payload
//   req       in          req_tvalid/req_tready   six BCD bytes in req_tdata
//   rsp       out         rsp_tvalid/rsp_tready   epoch seconds in rsp_tdata
//
// One beat is accepted per cycle while rsp is not stalled; each result passes
// through the six register stages (decode, products, divisions and day sum,
// hours, minutes, seconds). Reset clears the valid bits of all stages.
// A stall on rsp freezes the whole pipeline and drops req_tready; nothing is
// lost or repeated, and bubbles move up whenever the last stage is empty.
module bcd_rtc_date_to_epoch_seconds
   import bcdep_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sec_bcd, min_bcd, hour_bcd, date_bcd, month_bcd, year_bcd (lowest first)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // epoch_seconds
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic          en;
   logic          s1_valid;
   bcdep_dec_type s1_dec;

   logic        s2_valid_ff;
   logic [24:0] s2_p100_ff, s2_p100_in;
   logic [21:0] s2_p400_ff, s2_p400_in;
   logic [19:0] s2_y365_ff, s2_y365_in;
   logic [9:0]  s2_y4_ff;
   logic [13:0] s2_mm_ff, s2_mm_in;
   logic [5:0]  s2_day_ff, s2_hour_ff;
   logic [7:0]  s2_min_ff, s2_sec_ff;

   logic        s3_valid_ff;
   logic [27:0] s3_mo_ff, s3_mo_in;
   logic [31:0] s3_dpart_ff, s3_dpart_in;
   logic [5:0]  s3_hour_ff;
   logic [7:0]  s3_min_ff, s3_sec_ff;
   logic [24:0] q100_full;
   logic [21:0] q400_full;

   logic        s4_valid_ff;
   logic [31:0] s4_hrs_ff, s4_hrs_in;
   logic [31:0] days;
   logic [27:0] mo_full;
   logic [7:0]  s4_min_ff, s4_sec_ff;

   logic        s5_valid_ff;
   logic [31:0] s5_mins_ff, s5_mins_in;
   logic [7:0]  s5_sec_ff;

   logic        s6_valid_ff;
   logic [31:0] s6_secs_ff, s6_secs_in;

   assign en         = !s6_valid_ff || rsp_tready;
   assign req_tready = en;

   bcdep_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_data   (req_tdata),
      .out_valid (s1_valid),
      .out_dec   (s1_dec)
   );

   always_comb begin
      s2_p100_in = 25'({13'd0, s1_dec.year} * {12'd0, RECIP_100});
      s2_p400_in = 22'({10'd0, s1_dec.year} * {11'd0, RECIP_400});
      s2_y365_in = 20'({8'd0, s1_dec.year} * {11'd0, DAYS_PER_YEAR});
      s2_mm_in   = 14'({9'd0, s1_dec.mon} * {5'd0, MONTH_FACTOR});

      q100_full   = s2_p100_ff >> YEAR_RECIP_SH;
      q400_full   = s2_p400_ff >> YEAR_RECIP_SH;
      s3_mo_in    = 28'({14'd0, s2_mm_ff} * {14'd0, RECIP_12});
      s3_dpart_in = {12'd0, s2_y365_ff} + {22'd0, s2_y4_ff} - {7'd0, q100_full}
                    + {10'd0, q400_full} + {26'd0, s2_day_ff} - EPOCH_DAYS;

      mo_full   = s3_mo_ff >> MON_RECIP_SH;
      days      = s3_dpart_ff + {4'd0, mo_full};
      s4_hrs_in = (days << 4) + (days << 3) + {26'd0, s3_hour_ff};

      s5_mins_in = (s4_hrs_ff << 6) - (s4_hrs_ff << 2) + {24'd0, s4_min_ff};
      s6_secs_in = (s5_mins_ff << 6) - (s5_mins_ff << 2) + {24'd0, s5_sec_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_p100_ff  <= s2_p100_in;
         s2_p400_ff  <= s2_p400_in;
         s2_y365_ff  <= s2_y365_in;
         s2_y4_ff    <= s1_dec.year[11:2];
         s2_mm_ff    <= s2_mm_in;
         s2_day_ff   <= s1_dec.day;
         s2_hour_ff  <= s1_dec.hour;
         s2_min_ff   <= s1_dec.min;
         s2_sec_ff   <= s1_dec.sec;

         s3_mo_ff    <= s3_mo_in;
         s3_dpart_ff <= s3_dpart_in;
         s3_hour_ff  <= s2_hour_ff;
         s3_min_ff   <= s2_min_ff;
         s3_sec_ff   <= s2_sec_ff;

         s4_hrs_ff   <= s4_hrs_in;
         s4_min_ff   <= s3_min_ff;
         s4_sec_ff   <= s3_sec_ff;

         s5_mins_ff  <= s5_mins_in;
         s5_sec_ff   <= s4_sec_ff;

         s6_secs_ff  <= s6_secs_in;
      end
   end

   assign rsp_tvalid = s6_valid_ff;
   assign rsp_tdata  = s6_secs_ff;

endmodule

[sv/bcdep_checker.sv]
// Port-level checker for the RTC date to epoch converter, bound to the top level.
module bcdep_checker
   import bcdep_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result beat changed or vanished.");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("Input stalled while the output stage was free.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("Accepted beat did not reach the output in six cycles.");

endmodule

bind bcd_rtc_date_to_epoch_seconds bcdep_checker u_bcdep_checker (.*);
